/* src/mmmvs_pkg.sv */
// shared constants for the min/max/mean/variance statistics block
`default_nettype none
package mmmvs_pkg;

  // default sample store depth
  localparam int STORE_DEPTH_DEFAULT = 128;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 24;
  localparam int VAR_W       = 48;
  localparam int COUNT_OUT_W = 8;

  // deviation (mean_q8 - sample*256) and its square
  localparam int DIFF_W = MEAN_W + 1;
  localparam int SQ_W   = 2 * (MEAN_W);

  // fraction bits of the mean
  localparam int FRAC_W = 8;

endpackage
`default_nettype wire

/* src/min_max_mean_variance_stats_core.sv */
// min / max / mean / population variance over a stored set of samples
//
// Usage: drive sample and last with start high; a transaction is taken at a
// rising edge where start is high and busy is low. While a set loads, busy
// stays low and one sample is taken per cycle. Each sample is written into
// the on-chip sample store (STORE_DEPTH entries) while min, max and sum are
// tracked. Samples past the store depth are dropped and set overflowed.
// The sample with last high closes the set; busy then rises and the block
// runs: a load state, one restoring divider pass for the mean, a sign fix
// state, a read pass over the store for the squared deviations (through the
// single read port and the subtract / multiply / accumulate pipeline), a
// second load state and divider pass for the variance, and the output state.
// The result shows on the output ports with done high for one cycle; the
// receiver cannot stall, so it must take it then. busy falls in the same
// cycle and the next set can start immediately.
// Reset (synchronous, active high) empties the set and returns to idle; the
// store itself is not cleared, only entries written in the current set are
// read.
`default_nettype none
module min_max_mean_variance_stats_core #(
  parameter int STORE_DEPTH = mmmvs_pkg::STORE_DEPTH_DEFAULT
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  wire  signed [mmmvs_pkg::SAMPLE_W-1:0]   sample,
  input  wire                                     last,
  output logic                                    done,
  output logic signed [mmmvs_pkg::SAMPLE_W-1:0]   minimum,
  output logic signed [mmmvs_pkg::SAMPLE_W-1:0]   maximum,
  output logic signed [mmmvs_pkg::MEAN_W-1:0]     mean_q8,
  output logic        [mmmvs_pkg::VAR_W-1:0]      variance_q16,
  output logic        [mmmvs_pkg::COUNT_OUT_W-1:0] sample_count,
  output logic                                    overflowed
);
  import mmmvs_pkg::*;

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int SW   = SAMPLE_W + CW + 1;
  localparam int ACCW = SQ_W + CW;
  localparam int SCW  = $clog2(ACCW + 1);
  localparam int XW   = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_LOAD,
    ST_MEAN_DIV,
    ST_MEAN_FIX,
    ST_VAR_PASS,
    ST_VAR_LOAD,
    ST_VAR_DIV,
    ST_FINISH
  } state_t;

  state_t st;

  // set state
  logic        [CW-1:0]       kept_count;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SW-1:0]       run_sum;
  logic                       dropped;

  // sample store
  logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic        [CW-1:0]       issue_cnt;
  logic                       wr_en;

  // shared restoring divider
  logic [ACCW-1:0] quo;
  logic [CW-1:0]   rem;
  logic [SCW-1:0]  step_cnt;
  logic [CW:0]     div_sh;
  logic [CW:0]     div_sub;
  logic            div_ge;

  // mean and variance pipeline
  logic                        sum_neg;
  logic        [SW-1:0]        sum_mag;
  logic signed [MEAN_W-1:0]    mean_reg;
  logic                        rd_vld;
  logic                        d_vld;
  logic                        sq_vld;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [2*DIFF_W-1:0]  prod;
  logic        [SQ_W-1:0]      sq;
  logic        [ACCW-1:0]      acc;
  logic        [XW-1:0]        cnt_ext;

  logic accept;
  logic full;

  assign busy    = (st != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (kept_count == CW'(STORE_DEPTH));
  assign wr_en   = accept && !full;

  // magnitude of the running sum for the mean division
  assign sum_neg = run_sum[SW-1];
  assign sum_mag = sum_neg ? (SW'(0) - run_sum) : run_sum;

  // one divider step: shift in next dividend bit, compare with count
  assign div_sh  = {rem, quo[ACCW-1]};
  assign div_ge  = (div_sh >= (CW+1)'(kept_count));
  assign div_sub = div_sh - (CW+1)'(kept_count);

  // squared deviation
  assign prod    = diff * diff;
  assign cnt_ext = XW'(kept_count);

  // store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[kept_count[AW-1:0]] <= sample;
    end
    rd_data <= store_mem[issue_cnt[AW-1:0]];
  end

  // state, set tracking and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      done       <= 1'b0;
      kept_count <= '0;
      run_min    <= '0;
      run_max    <= '0;
      run_sum    <= '0;
      dropped    <= 1'b0;
      rd_vld     <= 1'b0;
      d_vld      <= 1'b0;
      sq_vld     <= 1'b0;
      issue_cnt  <= '0;
      step_cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        // load samples
        ST_IDLE: begin
          if (accept) begin
            if (!full) begin
              if (kept_count == '0) begin
                run_min <= sample;
                run_max <= sample;
              end else begin
                if (sample < run_min) run_min <= sample;
                if (sample > run_max) run_max <= sample;
              end
              run_sum    <= run_sum + SW'(sample);
              kept_count <= kept_count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              st <= ST_MEAN_LOAD;
            end
          end
        end

        // mean = |sum| * 256 / count
        ST_MEAN_LOAD: begin
          quo      <= ACCW'({sum_mag, {FRAC_W{1'b0}}});
          rem      <= '0;
          step_cnt <= '0;
          st       <= ST_MEAN_DIV;
        end

        ST_MEAN_DIV: begin
          quo      <= {quo[ACCW-2:0], div_ge};
          rem      <= div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0];
          step_cnt <= step_cnt + SCW'(1);
          if (step_cnt == SCW'(ACCW - 1)) begin
            st <= ST_MEAN_FIX;
          end
        end

        // restore sign, truncation toward zero
        ST_MEAN_FIX: begin
          mean_reg  <= sum_neg ? (MEAN_W'(0) - quo[MEAN_W-1:0])
                               : quo[MEAN_W-1:0];
          acc       <= '0;
          issue_cnt <= '0;
          st        <= ST_VAR_PASS;
        end

        // read pass: read, subtract, square, accumulate
        ST_VAR_PASS: begin
          rd_vld <= (issue_cnt < kept_count);
          if (issue_cnt < kept_count) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          d_vld  <= rd_vld;
          diff   <= DIFF_W'(mean_reg) - DIFF_W'($signed({rd_data, {FRAC_W{1'b0}}}));
          sq_vld <= d_vld;
          sq     <= prod[SQ_W-1:0];
          if (sq_vld) begin
            acc <= acc + ACCW'(sq);
          end
          if (issue_cnt == kept_count && !rd_vld && !d_vld && !sq_vld) begin
            st <= ST_VAR_LOAD;
          end
        end

        // variance = sum of squares / count
        ST_VAR_LOAD: begin
          quo      <= acc;
          rem      <= '0;
          step_cnt <= '0;
          st       <= ST_VAR_DIV;
        end

        ST_VAR_DIV: begin
          quo      <= {quo[ACCW-2:0], div_ge};
          rem      <= div_ge ? div_sub[CW-1:0] : div_sh[CW-1:0];
          step_cnt <= step_cnt + SCW'(1);
          if (step_cnt == SCW'(ACCW - 1)) begin
            st <= ST_FINISH;
          end
        end

        // present the result and clear the set
        ST_FINISH: begin
          minimum      <= run_min;
          maximum      <= run_max;
          mean_q8      <= mean_reg;
          variance_q16 <= quo[VAR_W-1:0];
          sample_count <= cnt_ext[COUNT_OUT_W-1:0];
          overflowed   <= dropped;
          done         <= 1'b1;
          kept_count   <= '0;
          run_min      <= '0;
          run_max      <= '0;
          run_sum      <= '0;
          dropped      <= 1'b0;
          st           <= ST_IDLE;
        end

        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* dv/tb_min_max_mean_variance_stats_core.sv */
// testbench for the min/max/mean/variance statistics core: directed sets, random sets, self-check
module tb_min_max_mean_variance_stats_core;
  import mmmvs_pkg::*;

  localparam int DEPTH         = STORE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 400;
  localparam int N_ROWS        = 20;

  // one set result as the block reports it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic signed [MEAN_W-1:0]   mean_q8;
    logic [VAR_W-1:0]           variance_q16;
    logic [COUNT_OUT_W-1:0]     sample_count;
    logic                       overflowed;
  } stats_t;

  // directed row: one value sent reps times, last on the final copy if closes
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    int unsigned                reps;
    logic                       closes;
    logic                       typed;
    stats_t                     want;
  } stim_row_t;

  localparam stats_t NO_RESULT = '0;

  logic                          clk    = 1'b0;
  logic                          rst    = 1'b1;
  logic                          start  = 1'b0;
  logic signed [SAMPLE_W-1:0]    sample = '0;
  logic                          last   = 1'b0;
  logic                          busy;
  logic                          done;
  logic signed [SAMPLE_W-1:0]    minimum;
  logic signed [SAMPLE_W-1:0]    maximum;
  logic signed [MEAN_W-1:0]      mean_q8;
  logic [VAR_W-1:0]              variance_q16;
  logic [COUNT_OUT_W-1:0]        sample_count;
  logic                          overflowed;

  // predicted set results waiting for the block
  stats_t pending_stats[$];
  int     mismatches = 0;

  // predictor copy of the set being loaded
  logic signed [SAMPLE_W-1:0] set_samples [DEPTH];
  int unsigned                set_count   = 0;
  logic signed [SAMPLE_W-1:0] set_min     = '0;
  logic signed [SAMPLE_W-1:0] set_max     = '0;
  longint                     set_sum     = 0;
  logic                       set_dropped = 1'b0;

  // extremes, truncation toward zero, full store, dropped samples
  stim_row_t dir_rows [N_ROWS] = '{
    '{16'sh8000, 1,   1'b1, 1'b1,
      '{16'sh8000, 16'sh8000, 24'sh800000, 48'd0, 8'd1, 1'b0}},
    '{16'sh7fff, 1,   1'b1, 1'b1,
      '{16'sh7fff, 16'sh7fff, 24'sh7fff00, 48'd0, 8'd1, 1'b0}},
    '{16'sh0000, 1,   1'b1, 1'b1,
      '{16'sh0000, 16'sh0000, 24'sh000000, 48'd0, 8'd1, 1'b0}},
    '{16'sh8000, 1,   1'b0, 1'b0, NO_RESULT},
    '{16'sh7fff, 1,   1'b1, 1'b0, NO_RESULT},
    '{16'sd1,    1,   1'b0, 1'b0, NO_RESULT},
    '{16'sd0,    2,   1'b1, 1'b0, NO_RESULT},
    '{-16'sd1,   1,   1'b0, 1'b0, NO_RESULT},
    '{16'sd0,    2,   1'b1, 1'b0, NO_RESULT},
    '{16'sh7fff, 64,  1'b0, 1'b0, NO_RESULT},
    '{16'sh8000, 64,  1'b1, 1'b0, NO_RESULT},
    '{16'sh7fff, 128, 1'b0, 1'b0, NO_RESULT},
    '{16'sh8000, 1,   1'b1, 1'b1,
      '{16'sh7fff, 16'sh7fff, 24'sh7fff00, 48'd0, 8'd128, 1'b1}},
    '{16'sh8000, 128, 1'b0, 1'b0, NO_RESULT},
    '{16'sd5,    3,   1'b0, 1'b0, NO_RESULT},
    '{16'sd7,    1,   1'b1, 1'b1,
      '{16'sh8000, 16'sh8000, 24'sh800000, 48'd0, 8'd128, 1'b1}},
    '{16'sh5555, 1,   1'b0, 1'b0, NO_RESULT},
    '{16'shaaaa, 1,   1'b0, 1'b0, NO_RESULT},
    '{16'sd300,  1,   1'b0, 1'b0, NO_RESULT},
    '{-16'sd300, 1,   1'b1, 1'b0, NO_RESULT}
  };

  min_max_mean_variance_stats_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .last         (last),
    .done         (done),
    .minimum      (minimum),
    .maximum      (maximum),
    .mean_q8      (mean_q8),
    .variance_q16 (variance_q16),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

  always #1 clk = ~clk;

  // fold one accepted sample into the set; returns 1 with the stats when it closes the set
  function automatic bit absorb_sample(input logic signed [SAMPLE_W-1:0] value,
                                       input logic closes, output stats_t res);
    longint      avg_q8;
    longint      dev;
    logic [63:0] mag;
    logic [63:0] sq_acc;
    logic [63:0] var_full;
    res = NO_RESULT;
    if (set_count < DEPTH) begin
      set_samples[set_count] = value;
      if (set_count == 0) begin
        set_min = value;
        set_max = value;
      end else begin
        if (value < set_min) set_min = value;
        if (value > set_max) set_max = value;
      end
      set_sum += value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!closes) return 1'b0;

    // mean in q8, then truncated mean of squared deviations in q16
    avg_q8 = (set_sum * 256) / longint'(set_count);
    sq_acc = '0;
    for (int i = 0; i < set_count; i++) begin
      dev = avg_q8 - longint'(set_samples[i]) * 256;
      mag = (dev < 0) ? -dev : dev;
      sq_acc += mag * mag;
    end
    var_full = sq_acc / set_count;
    res.minimum      = set_min;
    res.maximum      = set_max;
    res.mean_q8      = avg_q8[MEAN_W-1:0];
    res.variance_q16 = var_full[VAR_W-1:0];
    res.sample_count = set_count[COUNT_OUT_W-1:0];
    res.overflowed   = set_dropped;

    // set state clears after each result
    set_count   = 0;
    set_min     = '0;
    set_max     = '0;
    set_sum     = 0;
    set_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
    if (pick < 30) return SAMPLE_W'($signed($urandom_range(32)) - 16);
    return SAMPLE_W'($urandom);
  endfunction

  // mostly short sets, some long, a few past the store depth
  function automatic int random_set_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(8, 1);
    if (pick < 88) return $urandom_range(40, 9);
    if (pick < 97) return $urandom_range(DEPTH, 41);
    return $urandom_range(DEPTH + 8, DEPTH + 1);
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // one transaction: optional idle cycles with noise on the data, then hold until taken
  task automatic push_item(input logic signed [SAMPLE_W-1:0] value, input logic closes,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start  <= 1'b0;
      sample <= SAMPLE_W'($urandom);
      last   <= 1'($urandom);
    end
    @(negedge clk);
    start  <= 1'b1;
    sample <= value;
    last   <= closes;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_sets(input int item_goal, input int idle_pct);
    int                         sent;
    int                         size;
    logic signed [SAMPLE_W-1:0] value;
    stats_t                     res;
    sent = 0;
    while (sent < item_goal) begin
      size = random_set_size();
      for (int k = 0; k < size; k++) begin
        value = random_sample();
        push_item(value, k == size - 1, idle_pct);
        if (absorb_sample(value, k == size - 1, res)) pending_stats.push_back(res);
      end
      sent += size;
    end
  endtask

  // compare each result strobe with the oldest prediction
  always @(posedge clk) begin : result_check
    stats_t want;
    if (!rst && done) begin
      if (pending_stats.size() == 0) begin
        $error("result with no transaction waiting");
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("minimum", want.minimum, minimum);
        check_field("maximum", want.maximum, maximum);
        check_field("mean_q8", want.mean_q8, mean_q8);
        check_field("variance_q16", want.variance_q16, variance_q16);
        check_field("sample_count", want.sample_count, sample_count);
        check_field("overflowed", want.overflowed, overflowed);
      end
    end
  end

  // stimulus
  initial begin
    stats_t res;
    logic   closes;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        closes = dir_rows[i].closes && (k == dir_rows[i].reps - 1);
        push_item(dir_rows[i].value, closes, 26);
        if (absorb_sample(dir_rows[i].value, closes, res))
          pending_stats.push_back(dir_rows[i].typed ? dir_rows[i].want : res);
      end
    end
    wait_for_results();

    // random sets: light sender idling, heavy idling, then back to back
    run_random_sets(190, 26);
    wait_for_results();
    run_random_sets(190, 66);
    run_random_sets(170, 0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** min_max_mean_variance_stats_core: PASSED **");
    end else begin
      $display("** min_max_mean_variance_stats_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** min_max_mean_variance_stats_core: FAILED **");
    $finish;
  end

endmodule

/* files.f */
src/mmmvs_pkg.sv
src/min_max_mean_variance_stats_core.sv
dv/tb_min_max_mean_variance_stats_core.sv
